@@ sv/quantized_rgb_histogram_assert.svh @@
// assertion macros for the quantized rgb histogram
`ifndef QUANTIZED_RGB_HISTOGRAM_ASSERT_SVH
`define QUANTIZED_RGB_HISTOGRAM_ASSERT_SVH

// checked on every rising clock edge out of reset
`define QRH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qrh assertion failed");

// checked on every rising clock edge, reset included
`define QRH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("qrh assertion failed");

`endif

@@ sv/qrh_pkg.sv @@
// types and constants shared by the histogram files
`default_nettype none

package qrh_pkg;

  localparam int VALUE_W     = 8;
  localparam int BIN_IDX_W   = 7;
  localparam int COUNT_OUT_W = 20;
  localparam int NORM_W      = 27;
  localparam int IN_CHANNELS = 3;

  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

  // output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_LVL_W = 3;

  typedef enum logic {
    ACT_ACCUM = 1'b0,
    ACT_READ  = 1'b1
  } action_e;

  typedef struct packed {
    logic                 action;
    logic [VALUE_W-1:0]   chan0_value;
    logic [VALUE_W-1:0]   chan1_value;
    logic [VALUE_W-1:0]   chan2_value;
    logic [BIN_IDX_W-1:0] bin_index;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] bin_count;
    logic [NORM_W-1:0]      bin_normalized;
  } out_word_t;

  // per bank command: touch an entry, and whether it is cleared or bumped
  typedef struct packed {
    logic en;
    logic clr;
  } bank_req_t;

endpackage

`default_nettype wire

@@ sv/qrh_if.sv @@
// handshake channels of the histogram: input word, result word, scale write
`default_nettype none

interface qrh_in_if;
  import qrh_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qrh_out_if;
  import qrh_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qrh_cfg_if;
  import qrh_pkg::*;
  logic              valid;
  logic              ready;
  logic [NORM_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/qrh_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module qrh_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/qrh_bank.sv @@
// one channel bank: counter ram, valid bits, forwarding and read-modify-write
`default_nettype none

module qrh_bank #(
  parameter int DEPTH = 32,
  parameter int CW    = 20
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire qrh_pkg::bank_req_t       req_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  output logic      [CW-1:0]            cur_o
);
  import qrh_pkg::*;

  localparam int AW = $clog2(DEPTH);

  bank_req_t         s1_req_q;
  logic [AW-1:0]     s1_addr_q;
  logic              fwd_en_q;
  logic [AW-1:0]     fwd_addr_q;
  logic [CW-1:0]     fwd_data_q;
  logic [DEPTH-1:0]  vld_q;
  logic [CW-1:0]     rdata;
  logic [CW-1:0]     wdata;

  qrh_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (s1_req_q.en),
    .waddr_i (s1_addr_q),
    .wdata_i (wdata),
    .re_i    (req_i.en),
    .raddr_i (addr_i),
    .rdata_o (rdata)
  );

  // the write of the previous cycle is not yet visible in the ram read
  always_comb begin
    if (fwd_en_q && (fwd_addr_q == s1_addr_q)) begin
      cur_o = fwd_data_q;
    end else if (vld_q[s1_addr_q]) begin
      cur_o = rdata;
    end else begin
      cur_o = '0;
    end
  end

  // clear on read, saturating bump on accumulate
  always_comb begin
    if (s1_req_q.clr) begin
      wdata = '0;
    end else if (cur_o == {CW{1'b1}}) begin
      wdata = cur_o;
    end else begin
      wdata = cur_o + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_req_q <= '0;
      fwd_en_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      s1_req_q <= req_i;
      fwd_en_q <= s1_req_q.en;
      if (s1_req_q.en) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= addr_i;
    fwd_addr_q <= s1_addr_q;
    fwd_data_q <= wdata;
  end

endmodule

`default_nettype wire

@@ sv/qrh_outq.sv @@
// normalize stage and result queue
`default_nettype none

module qrh_outq #(
  parameter int CW = 20
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire logic [CW-1:0]                  count_i,
  input  wire logic [qrh_pkg::NORM_W-1:0]     scale_i,
  qrh_out_if.source                           out_o,
  output logic      [qrh_pkg::OQ_LVL_W-1:0]   level_o
);
  import qrh_pkg::*;

  localparam int PW = CW + NORM_W;

  logic                s2_vld_q;
  logic [CW-1:0]       s2_cnt_q;
  logic [PW-1:0]       prod;
  out_word_t           res;
  out_word_t           fifo_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_q;
  logic [OQ_PTR_W-1:0] rd_ptr_q;
  logic [OQ_LVL_W-1:0] cnt_q;
  logic                pop;

  // count times reciprocal, saturated to the q0.27 field
  always_comb begin
    prod               = PW'(s2_cnt_q) * PW'(scale_i);
    res.bin_count      = COUNT_OUT_W'(s2_cnt_q);
    res.bin_normalized = (prod > PW'(NORM_MAX)) ? NORM_MAX : prod[NORM_W-1:0];
  end

  assign pop         = out_o.valid & out_o.ready;
  assign out_o.valid = (cnt_q != '0);
  assign out_o.data  = fifo_q[rd_ptr_q];
  assign level_o     = cnt_q + OQ_LVL_W'(s2_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      s2_vld_q <= push_i;
      if (s2_vld_q) begin
        wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
      end
      cnt_q <= cnt_q + OQ_LVL_W'(s2_vld_q) - OQ_LVL_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    s2_cnt_q <= count_i;
    if (s2_vld_q) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

endmodule

`default_nettype wire

@@ sv/quantized_rgb_histogram.sv @@
// top level of the quantized per-channel color histogram
//
// channels: in_i takes one word per pixel or per bin read, out_o gives one
// word per bin read, cfg_i writes the normalization reciprocal (always ready)
// an accumulate word quantizes each channel value to a level and bumps one
// saturating counter in each channel bank; a read word returns a bin's count
// and count times the reciprocal, then clears the bin
// throughput: one word per cycle while in_i.ready is high, kept by the read-modify-write
// on each bank ram, with the previous write forwarded on a same-entry hit
// a read's result goes through the bank ram read, the modify and write back, then
// the registered multiply into the result queue, where it waits for out_o.ready
// reset: all counters read as zero through per-entry valid bits, no sweep,
// the reciprocal is zero and the result queue is empty
// stall: a four-entry result queue absorbs the pipeline, in_i.ready drops
// only when queued plus in-flight reads already fill it
// bin_index is channel times levels plus level; bins out of range read 0
`default_nettype none

module quantized_rgb_histogram #(
  parameter int QUANT_STEP   = 8,
  parameter int NUM_CHANNELS = 3,
  parameter int COUNT_WIDTH  = 20
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qrh_in_if.sink    in_i,
  qrh_out_if.source out_o,
  qrh_cfg_if.sink   cfg_i
);
  import qrh_pkg::*;

  localparam int LEVELS = 256 / QUANT_STEP;
  localparam int TOTAL  = NUM_CHANNELS * LEVELS;
  localparam int AW     = $clog2(LEVELS);
  localparam int CHW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // level = value * RECIP >> 16, exact for 8-bit values
  localparam int RECIP  = (65536 + QUANT_STEP - 1) / QUANT_STEP;
  localparam int MW     = 25;
  localparam int IXW    = 11;

  logic                 accept;
  logic [NORM_W-1:0]    scale_q;
  logic [VALUE_W-1:0]   chan_val [IN_CHANNELS];
  logic [AW-1:0]        acc_lvl  [IN_CHANNELS];
  logic [CHW-1:0]       rd_chan;
  logic [AW-1:0]        rd_lvl;
  logic                 rd_hit;
  bank_req_t            req      [NUM_CHANNELS];
  logic [AW-1:0]        req_addr [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] cur    [NUM_CHANNELS];
  logic                 s1_rd_q;
  logic                 s1_hit_q;
  logic [CHW-1:0]       s1_chan_q;
  logic [COUNT_WIDTH-1:0] s1_count;
  logic [OQ_LVL_W-1:0]  level;
  logic [OQ_LVL_W:0]    inflight;

  // scale register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
    end else if (cfg_i.valid) begin
      scale_q <= cfg_i.data;
    end
  end

  // queued results plus reads in flight must stay within the queue
  assign inflight   = (OQ_LVL_W+1)'(level) + (OQ_LVL_W+1)'(s1_rd_q);
  assign in_i.ready = (inflight < (OQ_LVL_W+1)'(OQ_DEPTH));
  assign accept     = in_i.valid & in_i.ready;

  assign chan_val[0] = in_i.data.chan0_value;
  assign chan_val[1] = in_i.data.chan1_value;
  assign chan_val[2] = in_i.data.chan2_value;

  // quantize each channel value by reciprocal multiply, clamp to last level
  always_comb begin
    logic [MW-1:0] prod;
    logic [8:0]    q;
    for (int c = 0; c < IN_CHANNELS; c++) begin
      prod = MW'(chan_val[c]) * MW'(RECIP);
      q    = prod[MW-1:16];
      if (q >= 9'(LEVELS)) begin
        acc_lvl[c] = AW'(LEVELS - 1);
      end else begin
        acc_lvl[c] = q[AW-1:0];
      end
    end
  end

  // split a bin number into channel and level by range compares
  always_comb begin
    logic [IXW-1:0] idx;
    logic [IXW-1:0] base;
    idx     = IXW'(in_i.data.bin_index);
    base    = '0;
    rd_chan = '0;
    for (int c = 1; c < NUM_CHANNELS; c++) begin
      if (idx >= IXW'(c * LEVELS)) begin
        rd_chan = CHW'(c);
        base    = IXW'(c * LEVELS);
      end
    end
    rd_hit = (idx < IXW'(TOTAL));
    rd_lvl = AW'(idx - base);
  end

  // bank commands
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (in_i.data.action == ACT_READ) begin
        req[c].en   = accept && rd_hit && (rd_chan == CHW'(c));
        req[c].clr  = 1'b1;
        req_addr[c] = rd_lvl;
      end else begin
        req[c].en   = accept && (c < IN_CHANNELS);
        req[c].clr  = 1'b0;
        req_addr[c] = (c < IN_CHANNELS) ? acc_lvl[(c < IN_CHANNELS) ? c : 0] : '0;
      end
    end
  end

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_bank
    qrh_bank #(
      .DEPTH (LEVELS),
      .CW    (COUNT_WIDTH)
    ) u_bank (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req[g]),
      .addr_i (req_addr[g]),
      .cur_o  (cur[g])
    );
  end

  // read bookkeeping alongside the bank stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_rd_q <= 1'b0;
    end else begin
      s1_rd_q <= accept && (in_i.data.action == ACT_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_hit_q  <= rd_hit;
    s1_chan_q <= rd_chan;
  end

  // out-of-range bins read as zero
  assign s1_count = s1_hit_q ? cur[s1_chan_q] : '0;

  qrh_outq #(
    .CW (COUNT_WIDTH)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_rd_q),
    .count_i (s1_count),
    .scale_i (scale_q),
    .out_o   (out_o),
    .level_o (level)
  );

  `include "quantized_rgb_histogram_assert.svh"

  `QRH_ASSERT(a_queue_bound, inflight <= (OQ_LVL_W+1)'(OQ_DEPTH))
  `QRH_ASSERT(a_read_tracked, accept && in_i.data.action == ACT_READ |=> s1_rd_q)
  `QRH_ASSERT(a_accum_silent, accept && in_i.data.action == ACT_ACCUM |=> !s1_rd_q)
  `QRH_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (level == '0 && !s1_rd_q))

endmodule

`default_nettype wire

@@ tb/quantized_rgb_histogram_test.sv @@
// self-checking testbench for the quantized rgb histogram: directed table, then random words
`default_nettype none

module quantized_rgb_histogram_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qrh_pkg::*;

  // block geometry at the default parameters
  localparam int QSTEP  = 8;
  localparam int LEVELS = 256 / QSTEP;
  localparam int NBINS  = IN_CHANNELS * LEVELS;
  localparam int CNT_W  = COUNT_OUT_W;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // the pad covers accumulates still in flight
  localparam int DRAIN_PAD       = 8;
  // cycles with no handshake on any channel before the run is declared hung
  localparam int STALL_LIMIT     = 2000;
  localparam int WORDS_PER_PHASE = 345;
  localparam int NUM_PHASES      = 3;

  // directed rows: either a scale write or one input word, with an optional
  // hand-typed expectation for the read results that are obvious
  typedef enum logic {
    ROW_WORD  = 1'b0,
    ROW_SCALE = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    action_e                act;
    logic [VALUE_W-1:0]     c0;
    logic [VALUE_W-1:0]     c1;
    logic [VALUE_W-1:0]     c2;
    logic [BIN_IDX_W-1:0]   bin;
    logic [NORM_W-1:0]      scale;
    logic                   typed;
    logic [COUNT_OUT_W-1:0] cnt;
    logic [NORM_W-1:0]      norm;
  } stim_row_t;

  localparam int NUM_ROWS = 25;
  localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
    // reads straight after reset return empty bins
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd0,   27'd0, 1'b1, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_READ,  8'd255, 8'd255, 8'd255, 7'd95,  27'd0, 1'b1, 20'd0, 27'd0},
    // bins past the end read as zero
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd96,  27'd0, 1'b1, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd127, 27'd0, 1'b1, 20'd0, 27'd0},
    // accumulates, bin_index ignored; value extremes and level edges
    '{ROW_WORD,  ACT_ACCUM, 8'd0,   8'd0,   8'd0,   7'd127, 27'd0, 1'b0, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_ACCUM, 8'd255, 8'd255, 8'd255, 7'd0,   27'd0, 1'b0, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_ACCUM, 8'd255, 8'd255, 8'd255, 7'd0,   27'd0, 1'b0, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_ACCUM, 8'd7,   8'd8,   8'd15,  7'd0,   27'd0, 1'b0, 20'd0, 27'd0},
    // zero scale gives a zero normalized value
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd0,   27'd0, 1'b0, 20'd0, 27'd0},
    // largest legal scale, products overflow and clip
    '{ROW_SCALE, ACT_ACCUM, 8'd0,   8'd0,   8'd0,   7'd0,   27'd89478485, 1'b0, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd31,  27'd0, 1'b0, 20'd0, 27'd0},
    // channel values on a read are ignored
    '{ROW_WORD,  ACT_READ,  8'd255, 8'd255, 8'd255, 7'd63,  27'd0, 1'b0, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd95,  27'd0, 1'b0, 20'd0, 27'd0},
    // second read of the same bin sees it cleared
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd95,  27'd0, 1'b0, 20'd0, 27'd0},
    '{ROW_SCALE, ACT_ACCUM, 8'd0,   8'd0,   8'd0,   7'd0,   27'd1, 1'b0, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd32,  27'd0, 1'b0, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd33,  27'd0, 1'b0, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_ACCUM, 8'd170, 8'd85,  8'd128, 7'd96,  27'd0, 1'b0, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_ACCUM, 8'd170, 8'd85,  8'd128, 7'd96,  27'd0, 1'b0, 20'd0, 27'd0},
    // out of range read leaves the store alone
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd127, 27'd0, 1'b1, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd21,  27'd0, 1'b0, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd42,  27'd0, 1'b0, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd80,  27'd0, 1'b0, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd65,  27'd0, 1'b0, 20'd0, 27'd0},
    '{ROW_WORD,  ACT_READ,  8'd0,   8'd0,   8'd0,   7'd64,  27'd0, 1'b0, 20'd0, 27'd0}
  };

  logic clk_i;
  logic rst_ni;

  qrh_in_if  in_ch ();
  qrh_out_if out_ch ();
  qrh_cfg_if cfg_ch ();

  quantized_rgb_histogram dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // shadow of the counter banks and the reciprocal register
  logic [CNT_W-1:0]  bin_tally [NBINS];
  logic [NORM_W-1:0] scale_shadow;

  // expected read results, oldest first
  out_word_t pending_reads [$];

  int errors        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles   = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // expected behavior of one accepted word: bump three bins or read and clear one
  task automatic predict_word(input in_word_t w, output bit has_res, output out_word_t res);
    logic [VALUE_W-1:0] vals [IN_CHANNELS];
    int                 b;
    logic [63:0]        prod;
    logic [CNT_W-1:0]   cnt;
    vals[0] = w.chan0_value;
    vals[1] = w.chan1_value;
    vals[2] = w.chan2_value;
    has_res = 1'b0;
    res     = '0;
    if (w.action == ACT_ACCUM) begin
      // one saturating bump per channel bank
      for (int c = 0; c < IN_CHANNELS; c++) begin
        b = c * LEVELS + vals[c] / QSTEP;
        if (bin_tally[b] != CNT_SAT) begin
          bin_tally[b] = bin_tally[b] + 1'b1;
        end
      end
    end else begin
      cnt = '0;
      if (w.bin_index < NBINS) begin
        cnt = bin_tally[w.bin_index];
        bin_tally[w.bin_index] = '0;
      end
      // full-width product, clipped to the q0.27 field
      prod = 64'(cnt) * 64'(scale_shadow);
      res.bin_count      = cnt;
      res.bin_normalized = (prod > 64'(NORM_MAX)) ? NORM_MAX : prod[NORM_W-1:0];
      has_res = 1'b1;
    end
  endtask

  // offer one word at the falling edge, with random gaps in front;
  // returns at the falling edge after acceptance with valid still high
  task automatic push_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    bit        has_res;
    out_word_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_word(w, has_res, res);
    if (has_res) begin
      pending_reads.insert(pending_reads.size(), typed ? typed_res : res);
    end
    @(negedge clk_i);
  endtask

  // hold the input low until every read result is back, then let
  // trailing accumulates settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk_i);
    repeat (DRAIN_PAD) @(negedge clk_i);
  endtask

  // the reciprocal is only changed with the pipeline empty
  task automatic write_scale(input logic [NORM_W-1:0] v);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    scale_shadow = v;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // result receiver with random back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compare every accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("result word %h with no read pending", out_ch.data));
      end else begin
        want = pending_reads.pop_front();
        if (out_ch.data.bin_count !== want.bin_count) begin
          report_mismatch($sformatf("bin_count got %0d want %0d",
                                    out_ch.data.bin_count, want.bin_count));
        end
        if (out_ch.data.bin_normalized !== want.bin_normalized) begin
          report_mismatch($sformatf("bin_normalized got %0d want %0d",
                                    out_ch.data.bin_normalized, want.bin_normalized));
        end
      end
    end
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_word_t    w;
    out_word_t   typed_res;
    stim_row_t   r;
    int          n;
    logic [63:0] recip;
    logic [NORM_W-1:0] scale;

    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    rst_ni       = 1'b0;
    scale_shadow = '0;
    foreach (bin_tally[i]) bin_tally[i] = '0;

    // sender idles 29 of 100, receiver 85 of 100 for the directed part and phase 0
    send_idle_pct = 29;
    recv_idle_pct = 85;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      r = STIM_ROWS[i];
      if (r.kind == ROW_SCALE) begin
        write_scale(r.scale);
      end else begin
        w.action      = r.act;
        w.chan0_value = r.c0;
        w.chan1_value = r.c1;
        w.chan2_value = r.c2;
        w.bin_index   = r.bin;
        typed_res.bin_count      = r.cnt;
        typed_res.bin_normalized = r.norm;
        push_word(w, r.typed, typed_res);
      end
    end

    // random phases, each with its own reciprocal and idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      unique case (p)
        0: begin
          scale = NORM_W'($urandom_range(0, 1 << 20));
        end
        1: begin
          // a realistic reciprocal for some pixel count
          send_idle_pct = 85;
          recv_idle_pct = 29;
          n     = $urandom_range(1, 1000);
          recip = (64'd1 << 32) / (64'(n) * 64'd48);
          scale = recip[NORM_W-1:0];
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          scale = NORM_W'($urandom_range(0, 89478485));
        end
      endcase
      write_scale(scale);

      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        // sender holds off once until the result queue is empty
        if (p == 0 && k == WORDS_PER_PHASE / 2) begin
          drain_results();
        end
        w = '0;
        w.chan0_value = VALUE_W'($urandom_range(0, 255));
        w.chan1_value = VALUE_W'($urandom_range(0, 255));
        w.chan2_value = VALUE_W'($urandom_range(0, 255));
        w.bin_index   = BIN_IDX_W'($urandom_range(0, 127));
        if ($urandom_range(0, 99) < 35) begin
          w.action = ACT_READ;
          // mostly valid bins, now and then past the end
          if ($urandom_range(0, 99) < 88) begin
            w.bin_index = BIN_IDX_W'($urandom_range(0, NBINS - 1));
          end
        end else begin
          w.action = ACT_ACCUM;
          // dark pixels now and then so a few bins build up larger counts
          if ($urandom_range(0, 99) < 30) begin
            w.chan0_value = VALUE_W'($urandom_range(0, 15));
            w.chan1_value = VALUE_W'($urandom_range(0, 15));
            w.chan2_value = VALUE_W'($urandom_range(0, 15));
          end
        end
        push_word(w, 1'b0, '0);
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/qrh_pkg.sv
sv/qrh_if.sv
sv/qrh_ram.sv
sv/qrh_bank.sv
sv/qrh_outq.sv
sv/quantized_rgb_histogram.sv
tb/quantized_rgb_histogram_test.sv
